FILE: rtl/core/kts_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and decode functions for the keystroke stream unit.
// No dependencies; the unit, the decoder and the bench files import this package.
package kts_pkg;

	localparam logic [7:0] BACKSLASH   = 8'h5C;
	localparam logic [7:0] KEY_SHIFT   = 8'h53; // 'S'
	localparam logic [7:0] KEY_CTRL    = 8'h43; // 'C'
	localparam logic [7:0] KEY_ALT     = 8'h41; // 'A'
	localparam logic [7:0] NUL_BYTE    = 8'h00;
	localparam logic [7:0] CTRL_MASK   = 8'h1F;

	localparam logic [3:0] MOD_SHIFT   = 4'h3;
	localparam logic [3:0] MOD_CTRL    = 4'h4;
	localparam logic [3:0] MOD_ALT     = 4'h8;

	localparam int unsigned CTRL_BIT   = 2;
	localparam int unsigned ALT_BIT    = 3;

	typedef struct packed {
		logic [3:0] mods;
		logic       esc;
		logic       ext;
	} kts_state_t;

	typedef struct packed {
		logic [7:0] ascii;
		logic [7:0] scan;
		logic [3:0] mask;
		logic       last;
	} kts_key_t;

	typedef struct packed {
		logic     emit;
		kts_key_t key;
		logic     esc;
		logic     ext;
	} kts_fresh_t;

	function automatic logic is_letter(logic [7:0] b);
		return (b inside {[8'h41:8'h5A], [8'h61:8'h7A]});
	endfunction

	// Set-1 scancode of a letter, keyed by the low five bits (1 = A .. 26 = Z).
	function automatic logic [7:0] letter_scan(logic [4:0] idx);
		logic [7:0] s;
		case (idx)
			5'd1:    s = 8'h1E;
			5'd2:    s = 8'h30;
			5'd3:    s = 8'h2E;
			5'd4:    s = 8'h20;
			5'd5:    s = 8'h12;
			5'd6:    s = 8'h21;
			5'd7:    s = 8'h22;
			5'd8:    s = 8'h23;
			5'd9:    s = 8'h17;
			5'd10:   s = 8'h24;
			5'd11:   s = 8'h25;
			5'd12:   s = 8'h26;
			5'd13:   s = 8'h32;
			5'd14:   s = 8'h31;
			5'd15:   s = 8'h18;
			5'd16:   s = 8'h19;
			5'd17:   s = 8'h10;
			5'd18:   s = 8'h13;
			5'd19:   s = 8'h1F;
			5'd20:   s = 8'h14;
			5'd21:   s = 8'h16;
			5'd22:   s = 8'h2F;
			5'd23:   s = 8'h11;
			5'd24:   s = 8'h2D;
			5'd25:   s = 8'h15;
			5'd26:   s = 8'h2C;
			default: s = 8'h00;
		endcase
		return s;
	endfunction

	function automatic logic [7:0] scan_of(logic [7:0] b);
		logic [7:0] s;
		if (is_letter(b)) begin
			s = letter_scan(b[4:0]);
		end else if (b == 8'h30) begin
			s = 8'h0B;
		end else if (b inside {[8'h31:8'h39]}) begin
			s = b - 8'h2F;
		end else begin
			case (b)
				8'h0D, 8'h0A: s = 8'h1C;
				8'h20:        s = 8'h39;
				8'h1B:        s = 8'h01;
				8'h09:        s = 8'h0F;
				8'h08:        s = 8'h0E;
				8'h2D:        s = 8'h0C;
				8'h3D:        s = 8'h0D;
				8'h5B:        s = 8'h1A;
				8'h5D:        s = 8'h1B;
				8'h3B:        s = 8'h27;
				8'h27:        s = 8'h28;
				8'h60:        s = 8'h29;
				8'h5C:        s = 8'h2B;
				8'h2C:        s = 8'h33;
				8'h2E:        s = 8'h34;
				8'h2F:        s = 8'h35;
				default:      s = 8'h00;
			endcase
		end
		return s;
	endfunction

	// Decode a byte with no escape or extended pair open.
	function automatic kts_fresh_t fresh_decode(logic [7:0] b, logic last, logic [3:0] mods);
		kts_fresh_t f;
		f = '0;
		f.key.mask = mods;
		if (b == BACKSLASH) begin
			f.emit      = last;
			f.esc       = !last;
			f.key.ascii = BACKSLASH;
			f.key.scan  = scan_of(BACKSLASH);
		end else if (b == NUL_BYTE) begin
			f.emit      = last;
			f.ext       = !last;
			f.key.ascii = NUL_BYTE;
			f.key.scan  = NUL_BYTE;
		end else begin
			f.emit      = 1'b1;
			f.key.ascii = b;
			f.key.scan  = scan_of(b);
			if (is_letter(b)) begin
				if (mods[CTRL_BIT]) f.key.ascii = b & CTRL_MASK;
				if (mods[ALT_BIT])  f.key.ascii = NUL_BYTE;
			end
		end
		return f;
	endfunction

endpackage

FILE: rtl/core/kts_char_if.sv
`timescale 1ns / 1ps
// Valid/ready channel carrying one key-script byte per beat.
// No dependencies.
interface kts_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_byte;
	logic       end_of_string;

	modport source(output valid, char_byte, end_of_string, input ready);
	modport sink(input valid, char_byte, end_of_string, output ready);
endinterface

FILE: rtl/core/kts_key_if.sv
`timescale 1ns / 1ps
// Valid/ready channel carrying one keystroke per beat.
// No dependencies.
interface kts_key_if;
	logic       valid;
	logic       ready;
	logic [7:0] ascii_code;
	logic [7:0] scan_code;
	logic [3:0] modifier_mask;
	logic       last_of_run;

	modport source(output valid, ascii_code, scan_code, modifier_mask, last_of_run,
		input ready);
	modport sink(input valid, ascii_code, scan_code, modifier_mask, last_of_run,
		output ready);
endinterface

FILE: rtl/core/key_text_to_keystroke_stream_unit.sv
`timescale 1ns / 1ps
// Top level of the keystroke stream unit: input stage, decoder, two-entry key buffer.
// Depends on kts_pkg, kts_char_if, kts_key_if and kts_decode.
//
// Usage:
//   chars   - sink channel, one key-script byte per beat with an end_of_string flag.
//   strokes - source channel, one keystroke per beat (ASCII, set-1 scancode,
//             modifier mask, last_of_run marking the final key of a byte).
//   A byte yields zero, one or two keystrokes. Modifier toggles (backslash S/C/A)
//   and the first byte of an escape or extended pair yield none.
//
// Flow:
//   An accepted byte is registered in the input stage and moves, decoded, into
//   the key buffer once the buffer is empty or its last keystroke is taken; its
//   first keystroke is then offered from the key buffer.
//   One byte per cycle is taken while each byte yields at most one keystroke
//   and the receiver is ready; the output port moves one keystroke per cycle
//   while the receiver is ready. The key buffer and the input stage hold one
//   byte each, so a new byte is taken while a keystroke waits.
//
// Reset (arst_n low) empties both stages and clears the modifiers and the
// pending escape/extended flags. When the receiver stalls, keystrokes hold
// in the buffer, the input stage fills, and chars.ready drops.
module key_text_to_keystroke_stream_unit
	import kts_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	kts_char_if.sink    chars,
	kts_key_if.source   strokes
);

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eos_s1;

	// decoder state and key buffer
	kts_state_t st_q;
	kts_key_t   key_q [2];
	logic       head_q;
	logic [1:0] left_q;

	kts_state_t st_nxt;
	logic [1:0] dec_cnt;
	kts_key_t   dec_key0;
	kts_key_t   dec_key1;
	kts_key_t   head_key;

	logic in_fire;
	logic out_fire;
	logic move;

	kts_decode u_decode (
		.st            (st_q),
		.char_byte     (byte_s1),
		.end_of_string (eos_s1),
		.nxt           (st_nxt),
		.cnt           (dec_cnt),
		.key0          (dec_key0),
		.key1          (dec_key1)
	);

	assign out_fire = strokes.valid && strokes.ready;
	// Move the registered byte into the buffer once the buffer is empty or drains this cycle.
	assign move     = valid_s1 && ((left_q == 2'd0) || ((left_q == 2'd1) && out_fire));
	assign chars.ready = !valid_s1 || move;
	assign in_fire  = chars.valid && chars.ready;

	// Input stage: hold the byte until the decoder takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			byte_s1 <= chars.char_byte;
			eos_s1  <= chars.end_of_string;
		end
	end

	// Decoder state advances with every byte handed to the buffer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= '0;
			head_q <= 1'b0;
			left_q <= 2'd0;
		end else if (move) begin
			st_q   <= st_nxt;
			head_q <= 1'b0;
			left_q <= dec_cnt;
		end else if (out_fire) begin
			head_q <= !head_q;
			left_q <= left_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			key_q[0] <= dec_key0;
			key_q[1] <= dec_key1;
		end
	end

	// Drive the output beat from the head of the buffer.
	assign head_key              = key_q[head_q];
	assign strokes.valid         = (left_q != 2'd0);
	assign strokes.ascii_code    = head_key.ascii;
	assign strokes.scan_code     = head_key.scan;
	assign strokes.modifier_mask = head_key.mask;
	assign strokes.last_of_run   = head_key.last;

	// Buffer never holds more than one byte's two keys.
	a_left_range: assert property (@(posedge clk) disable iff (!arst_n)
		left_q != 2'd3)
		else $error("key buffer count out of range");

	// Two keys pending always start at the first slot.
	a_two_at_head: assert property (@(posedge clk) disable iff (!arst_n)
		(left_q == 2'd2) |-> (head_q == 1'b0))
		else $error("two keys pending but head advanced");

	// The key before the final one of a pair is never flagged last.
	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		(left_q == 2'd2) |-> !strokes.last_of_run)
		else $error("first key of a pair flagged last");

	// Back-pressure only while the input stage is occupied.
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!chars.ready |-> (valid_s1 && (left_q != 2'd0)))
		else $error("input stalled with room downstream");

	// A stalled byte is still waiting in the input stage on the next cycle.
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !move) |=> valid_s1)
		else $error("input stage dropped a byte");

endmodule

FILE: rtl/core/kts_decode.sv
`timescale 1ns / 1ps
// Byte decoder: turns one byte and the escape/modifier state into up to two keys.
// Depends on kts_pkg.
module kts_decode
	import kts_pkg::*;
(
	input  kts_state_t st,
	input  logic [7:0] char_byte,
	input  logic       end_of_string,
	output kts_state_t nxt,
	output logic [1:0] cnt,
	output kts_key_t   key0,
	output kts_key_t   key1
);

	kts_fresh_t fr;

	always_comb begin
		fr   = fresh_decode(char_byte, end_of_string, st.mods);
		nxt  = st;
		cnt  = 2'd0;
		key0 = fr.key;
		key1 = fr.key;
		if (st.ext) begin
			// raw extended scancode, passed verbatim
			nxt.ext    = 1'b0;
			key0.ascii = NUL_BYTE;
			key0.scan  = char_byte;
			key0.mask  = st.mods;
			cnt        = 2'd1;
		end else if (st.esc) begin
			nxt.esc = 1'b0;
			if (char_byte == KEY_SHIFT) begin
				nxt.mods = st.mods ^ MOD_SHIFT;
			end else if (char_byte == KEY_CTRL) begin
				nxt.mods = st.mods ^ MOD_CTRL;
			end else if (char_byte == KEY_ALT) begin
				nxt.mods = st.mods ^ MOD_ALT;
			end else begin
				// plain backslash first, then the byte decoded afresh
				key0.ascii = BACKSLASH;
				key0.scan  = scan_of(BACKSLASH);
				key0.mask  = st.mods;
				cnt        = fr.emit ? 2'd2 : 2'd1;
				nxt.esc    = fr.esc;
				nxt.ext    = fr.ext;
			end
		end else begin
			cnt     = fr.emit ? 2'd1 : 2'd0;
			nxt.esc = fr.esc;
			nxt.ext = fr.ext;
		end
		key0.last = (cnt == 2'd1);
		key1.last = 1'b1;
		if (end_of_string) nxt = '0;
	end

endmodule

FILE: sim/kts_keystroke_checker.sv
`timescale 1ns / 1ps
// Watches both channels of the keystroke stream unit, predicts each keystroke
// from the accepted script bytes and compares it. Depends on kts_pkg and the channel interfaces.
module kts_keystroke_checker
	import kts_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	kts_char_if         chars,
	kts_key_if          strokes,
	output int unsigned fail_count,
	output int unsigned strokes_waiting,
	output int unsigned strokes_matched
);

	// Set-1 codes of A..Z, A in the top byte.
	localparam logic [26*8-1:0] LETTER_SET1 = {
		8'h1E, 8'h30, 8'h2E, 8'h20, 8'h12, 8'h21, 8'h22, 8'h23, 8'h17,
		8'h24, 8'h25, 8'h26, 8'h32, 8'h31, 8'h18, 8'h19, 8'h10, 8'h13,
		8'h1F, 8'h14, 8'h16, 8'h2F, 8'h11, 8'h2D, 8'h15, 8'h2C
	};

	logic [3:0] held_mods;
	logic       esc_open;
	logic       ext_open;
	kts_key_t   strokes_due[$];

	function automatic logic alpha(logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
	endfunction

	function automatic logic [7:0] set1_code(logic [7:0] c);
		int         pos;
		logic [7:0] code;
		code = 8'h00;
		if (alpha(c)) begin
			pos = 26 - int'(c[4:0]);
			code = LETTER_SET1[pos*8 +: 8];
		end else if (c == 8'h30) begin
			code = 8'h0B;
		end else if (c >= 8'h31 && c <= 8'h39) begin
			code = c - 8'h2F;
		end else begin
			case (c)
				8'h0D, 8'h0A: code = 8'h1C;
				8'h20:        code = 8'h39;
				8'h1B:        code = 8'h01;
				8'h09:        code = 8'h0F;
				8'h08:        code = 8'h0E;
				8'h2D:        code = 8'h0C;
				8'h3D:        code = 8'h0D;
				8'h5B:        code = 8'h1A;
				8'h5D:        code = 8'h1B;
				8'h3B:        code = 8'h27;
				8'h27:        code = 8'h28;
				8'h60:        code = 8'h29;
				8'h5C:        code = 8'h2B;
				8'h2C:        code = 8'h33;
				8'h2E:        code = 8'h34;
				8'h2F:        code = 8'h35;
				default:      code = 8'h00;
			endcase
		end
		return code;
	endfunction

	function automatic kts_key_t make_key(logic [7:0] ascii, logic [7:0] scan);
		kts_key_t k;
		k.ascii = ascii;
		k.scan  = scan;
		k.mask  = held_mods;
		k.last  = 1'b0;
		return k;
	endfunction

	// Advance the decoder state by one byte and queue the keystrokes it causes.
	task automatic decode_script_byte(input logic [7:0] c, input logic eos);
		kts_key_t   keys [2];
		int         n;
		logic       fresh;
		logic [7:0] ascii;
		n = 0;
		fresh = 1'b1;
		if (ext_open) begin
			ext_open = 1'b0;
			fresh = 1'b0;
			keys[n] = make_key(NUL_BYTE, c);
			n++;
		end else if (esc_open) begin
			esc_open = 1'b0;
			if (c == KEY_SHIFT) begin
				held_mods ^= MOD_SHIFT;
				fresh = 1'b0;
			end else if (c == KEY_CTRL) begin
				held_mods ^= MOD_CTRL;
				fresh = 1'b0;
			end else if (c == KEY_ALT) begin
				held_mods ^= MOD_ALT;
				fresh = 1'b0;
			end else begin
				keys[n] = make_key(BACKSLASH, set1_code(BACKSLASH));
				n++;
			end
		end
		if (fresh) begin
			if (c == BACKSLASH) begin
				if (eos) begin
					keys[n] = make_key(BACKSLASH, set1_code(BACKSLASH));
					n++;
				end else begin
					esc_open = 1'b1;
				end
			end else if (c == NUL_BYTE) begin
				if (eos) begin
					keys[n] = make_key(NUL_BYTE, NUL_BYTE);
					n++;
				end else begin
					ext_open = 1'b1;
				end
			end else begin
				ascii = c;
				if (alpha(c) && held_mods[CTRL_BIT]) ascii = c & CTRL_MASK;
				if (alpha(c) && held_mods[ALT_BIT]) ascii = NUL_BYTE;
				keys[n] = make_key(ascii, set1_code(c));
				n++;
			end
		end
		if (n > 0) keys[n-1].last = 1'b1;
		for (int i = 0; i < n; i++) strokes_due.insert(strokes_due.size(), keys[i]);
		if (eos) begin
			held_mods = 4'h0;
			esc_open  = 1'b0;
			ext_open  = 1'b0;
		end
	endtask

	task automatic check_stroke();
		kts_key_t want;
		if (strokes_due.size() == 0) begin
			$error("keystroke with none due: ascii %02h scan %02h",
				strokes.ascii_code, strokes.scan_code);
			fail_count++;
		end else begin
			want = strokes_due[0];
			strokes_due.delete(0);
			strokes_matched++;
			if (strokes.ascii_code !== want.ascii) begin
				$error("ascii_code: expected %02h, got %02h", want.ascii, strokes.ascii_code);
				fail_count++;
			end
			if (strokes.scan_code !== want.scan) begin
				$error("scan_code: expected %02h, got %02h", want.scan, strokes.scan_code);
				fail_count++;
			end
			if (strokes.modifier_mask !== want.mask) begin
				$error("modifier_mask: expected %01h, got %01h", want.mask,
					strokes.modifier_mask);
				fail_count++;
			end
			if (strokes.last_of_run !== want.last) begin
				$error("last_of_run: expected %0b, got %0b", want.last, strokes.last_of_run);
				fail_count++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_mods = 4'h0;
			esc_open = 1'b0;
			ext_open = 1'b0;
			strokes_due.delete();
			fail_count = 0;
			strokes_waiting = 0;
			strokes_matched = 0;
		end else begin
			if (chars.valid && chars.ready)
				decode_script_byte(chars.char_byte, chars.end_of_string);
			if (strokes.valid && strokes.ready)
				check_stroke();
			strokes_waiting = strokes_due.size();
		end
	end

endmodule

FILE: sim/tb_key_text_to_keystroke_stream_unit.sv
`timescale 1ns / 1ps
// Top of the keystroke stream unit bench: clock, reset, script stimulus, receiver stalls and verdict.
// Depends on kts_pkg, kts_char_if, kts_key_if, kts_keystroke_checker and the unit itself.
module tb_key_text_to_keystroke_stream_unit;
	import kts_pkg::*;

	localparam int unsigned RANDOM_BYTES = 700;
	localparam int unsigned IDLE_LIMIT   = 2000; // cycles with no beat on either channel
	localparam int unsigned HOLD_AFTER   = 300;  // bytes sent before the long receiver stall
	localparam int unsigned HOLD_CYCLES  = 200;
	localparam int unsigned DRAIN_CYCLES = 20;

	logic clk;
	logic arst_n;

	kts_char_if chars_ch();
	kts_key_if  keys_ch();

	int unsigned fail_count;
	int unsigned strokes_waiting;
	int unsigned strokes_matched;

	int unsigned bytes_sent;
	int unsigned strings_sent;
	int unsigned burst_left;
	int unsigned idle_cycles;
	bit          hold_done;
	logic [7:0]  script_q[$];

	key_text_to_keystroke_stream_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.chars   (chars_ch),
		.strokes (keys_ch)
	);

	kts_keystroke_checker u_keystroke_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.chars           (chars_ch),
		.strokes         (keys_ch),
		.fail_count      (fail_count),
		.strokes_waiting (strokes_waiting),
		.strokes_matched (strokes_matched)
	);

	// 8 ns clock, 4 ns high and 4 ns low.
	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Offer one byte and hold it until the unit takes the beat. Bursts of random
	// length alternate with random gaps; a zero gap keeps valid high across bursts.
	task automatic send_byte(input logic [7:0] c, input logic eos);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 12);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				@(negedge clk);
				chars_ch.valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		chars_ch.valid         <= 1'b1;
		chars_ch.char_byte     <= c;
		chars_ch.end_of_string <= eos;
		do @(posedge clk); while (!chars_ch.ready);
		bytes_sent++;
	endtask

	// Send the staged script, flagging its final byte as the end of the string.
	task automatic send_script();
		for (int i = 0; i < script_q.size(); i++)
			send_byte(script_q[i], i == script_q.size() - 1);
		script_q.delete();
		strings_sent++;
	endtask

	// Append one byte to the staged script.
	task automatic stage_byte(input logic [7:0] c);
		script_q.insert(script_q.size(), c);
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++) stage_byte(s[i]);
	endtask

	// Mostly mapped keys: letters of both cases, digits, every mapped punctuation
	// and control byte but backslash, and now and then any byte at all.
	function automatic logic [7:0] pick_plain_char();
		int unsigned r;
		logic [7:0]  c;
		r = $urandom_range(0, 99);
		if (r < 50) begin
			c = ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'($urandom_range(0, 25));
		end else if (r < 65) begin
			c = 8'h30 + 8'($urandom_range(0, 9));
		end else if (r < 80) begin
			case ($urandom_range(0, 15))
				0:       c = 8'h0D;
				1:       c = 8'h0A;
				2:       c = 8'h20;
				3:       c = 8'h1B;
				4:       c = 8'h09;
				5:       c = 8'h08;
				6:       c = 8'h2D;
				7:       c = 8'h3D;
				8:       c = 8'h5B;
				9:       c = 8'h5D;
				10:      c = 8'h3B;
				11:      c = 8'h27;
				12:      c = 8'h60;
				13:      c = 8'h2C;
				14:      c = 8'h2E;
				default: c = 8'h2F;
			endcase
		end else begin
			c = 8'($urandom_range(0, 255));
		end
		return c;
	endfunction

	// Stage one random string. Most are built from well-formed pieces (modifier
	// toggles, extended pairs, backslash escapes, plain keys); the rest is noise
	// rich in backslash and zero bytes, so strings also end mid-pair.
	task automatic build_script();
		int unsigned pieces;
		int unsigned r;
		if ($urandom_range(0, 99) < 15) begin
			pieces = $urandom_range(1, 6);
			for (int i = 0; i < pieces; i++) begin
				r = $urandom_range(0, 4);
				if (r == 0) stage_byte(BACKSLASH);
				else if (r == 1) stage_byte(NUL_BYTE);
				else stage_byte(8'($urandom_range(0, 255)));
			end
		end else begin
			pieces = $urandom_range(1, 8);
			for (int i = 0; i < pieces; i++) begin
				r = $urandom_range(0, 99);
				if (r < 25) begin
					stage_byte(BACKSLASH);
					case ($urandom_range(0, 2))
						0:       stage_byte(KEY_SHIFT);
						1:       stage_byte(KEY_CTRL);
						default: stage_byte(KEY_ALT);
					endcase
				end else if (r < 35) begin
					stage_byte(NUL_BYTE);
					stage_byte(8'($urandom_range(0, 255)));
				end else if (r < 45) begin
					stage_byte(BACKSLASH);
					stage_byte(pick_plain_char());
				end else begin
					stage_byte(pick_plain_char());
				end
			end
		end
	endtask

	// Receiver: switch among stall patterns at random, with one long hold-off
	// mid-run so the key buffer and input stage fill and ready drops.
	initial begin
		int unsigned mode;
		int unsigned mode_left;
		keys_ch.ready = 1'b0;
		mode = 0;
		mode_left = 0;
		forever begin
			@(negedge clk);
			if (!hold_done && bytes_sent >= HOLD_AFTER) begin
				hold_done = 1'b1;
				keys_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(0, 3);
					mode_left = $urandom_range(10, 60);
				end
				mode_left--;
				case (mode)
					0:       keys_ch.ready <= 1'b1;
					1:       keys_ch.ready <= 1'($urandom_range(0, 1));
					2:       keys_ch.ready <= (mode_left % 3 != 0);
					default: keys_ch.ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// Watchdog: end the run when no beat moves on either channel for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((chars_ch.valid && chars_ch.ready) || (keys_ch.valid && keys_ch.ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		int unsigned random_start;
		arst_n                 = 1'b0;
		chars_ch.valid         = 1'b0;
		chars_ch.char_byte     = 8'h00;
		chars_ch.end_of_string = 1'b0;
		bytes_sent   = 0;
		strings_sent = 0;
		burst_left   = 0;
		idle_cycles  = 0;
		hold_done    = 1'b0;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Shift on a letter, ctrl stacked on shift, then alt over ctrl on the last letter.
		add_text("\\Sa\\Cz\\AZ");
		send_script();
		// Backslash before a plain key, then a backslash that opens a second escape.
		add_text("\\q\\\\x");
		send_script();
		// Backslash before a zero byte, a raw scancode, then a zero byte at string end.
		script_q = '{BACKSLASH, NUL_BYTE, 8'h48, NUL_BYTE};
		send_script();
		// Extended pair closing the string with an all-ones scancode.
		script_q = '{NUL_BYTE, 8'hFF};
		send_script();
		// Modifier toggle as the final byte: nothing emitted, modifiers clear.
		add_text("\\C");
		send_script();
		add_text("a");
		send_script();
		// Lone backslash as the whole string.
		script_q = '{BACKSLASH};
		send_script();
		// High bytes stay unmapped; DEL and carriage return close it out.
		script_q = '{8'h80, 8'h7F, 8'h0D};
		send_script();

		random_start = bytes_sent;
		while (bytes_sent - random_start < RANDOM_BYTES) begin
			build_script();
			send_script();
		end
		@(negedge clk);
		chars_ch.valid <= 1'b0;

		// Drain: wait for every predicted keystroke, then a quiet drain period to
		// catch anything extra.
		while (strokes_waiting != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Run covered %0d script bytes in %0d strings, %0d keystrokes compared,",
			bytes_sent, strings_sent, strokes_matched);
		$display("with bursty input, patterned receiver stalls and one %0d-cycle hold-off.",
			HOLD_CYCLES);
		if (fail_count == 0 && strokes_waiting == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
